// ===== sv/polyev_pkg.sv =====
package polyev_pkg;

  localparam int DATA_W     = 32;
  localparam int DEG_W      = 3;
  localparam int NUM_COEFS  = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int PROD_W     = 2 * DATA_W;

  localparam int MAX_DEGREE_DEF = 6;
  localparam int FRAC_BITS_DEF  = 16;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF0  = 3'd1;

  typedef logic [NUM_COEFS-1:0][DATA_W-1:0] coef_bank_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             load;
    logic             mul;
    logic             add;
    logic             emit;
    logic [DEG_W-1:0] coef_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/polyev_regs.sv =====
module polyev_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [polyev_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [polyev_pkg::DATA_W-1:0]       cfg_data,
  output logic [polyev_pkg::DEG_W-1:0]        degree,
  output polyev_pkg::coef_bank_t              coefs
);

  logic [polyev_pkg::DEG_W-1:0]     degree_r;
  polyev_pkg::coef_bank_t           coef_r;
  logic [polyev_pkg::CFG_IDX_W-1:0] coef_idx;

  assign coef_idx = cfg_index - polyev_pkg::REG_COEF0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= '0;
      coef_r   <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == polyev_pkg::REG_DEGREE) begin
        degree_r <= cfg_data[polyev_pkg::DEG_W-1:0];
      end else begin
        coef_r[coef_idx] <= cfg_data;
      end
    end
  end

  assign degree = degree_r;
  assign coefs  = coef_r;

endmodule

// ===== sv/polyev_dp.sv =====
module polyev_dp #(
  parameter int FRAC_BITS = polyev_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  polyev_pkg::dp_cmd_t                  cmd,
  output polyev_pkg::dp_status_t               status,
  input  polyev_pkg::coef_bank_t               coefs,
  input  logic signed [polyev_pkg::DATA_W-1:0] in_x_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [polyev_pkg::DATA_W-1:0] out_poly_value,
  output logic                                 out_overflow
);

  localparam int DW = polyev_pkg::DATA_W;
  localparam int PW = polyev_pkg::PROD_W;

  logic signed [DW-1:0] x_r, acc_r, acc_nxt;
  logic signed [PW-1:0] prod_r, shifted;
  logic [PW:0]          sum;
  logic [DW-1:0]        coef;
  logic                 ovf_r, ovf_nxt, step_sat;
  logic                 out_valid_r;
  logic [DW-1:0]        out_val_r;
  logic                 out_ovf_r;

  assign coef    = coefs[cmd.coef_sel];
  assign shifted = prod_r >>> FRAC_BITS;
  assign sum     = {shifted[PW-1], shifted} + {{(PW-DW+1){coef[DW-1]}}, coef};

  // sum fits 32 bits only if all bits from the sign of the narrow word up match
  assign step_sat = !((&sum[PW:DW-1]) || !(|sum[PW:DW-1]));

  always_comb begin
    acc_nxt = acc_r;
    ovf_nxt = ovf_r;
    if (cmd.load) begin
      acc_nxt = coef;
      ovf_nxt = 1'b0;
    end else if (cmd.add) begin
      if (step_sat) begin
        acc_nxt = sum[PW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        ovf_nxt = 1'b1;
      end else begin
        acc_nxt = sum[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    ovf_r <= ovf_nxt;
    if (cmd.load) begin
      x_r <= in_x_value;
    end
    if (cmd.mul) begin
      prod_r <= acc_r * x_r;
    end
    if (cmd.emit) begin
      out_val_r <= acc_r;
      out_ovf_r <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_poly_value  = out_val_r;
  assign out_overflow    = out_ovf_r;

endmodule

// ===== sv/polyev_ctrl.sv =====
module polyev_ctrl #(
  parameter int MAX_DEGREE = polyev_pkg::MAX_DEGREE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [polyev_pkg::DEG_W-1:0]  degree,
  input  polyev_pkg::dp_status_t        status,
  output polyev_pkg::dp_cmd_t           cmd
);

  polyev_pkg::state_t             state_r, state_nxt;
  logic [polyev_pkg::DEG_W-1:0]   step_r, step_nxt;
  logic [polyev_pkg::DEG_W-1:0]   deg_eff;

  // degrees past the configured maximum clamp to it
  assign deg_eff = (degree > polyev_pkg::DEG_W'(MAX_DEGREE)) ?
                   polyev_pkg::DEG_W'(MAX_DEGREE) : degree;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      polyev_pkg::ST_IDLE: begin
        if (in_valid) begin
          step_nxt  = deg_eff;
          state_nxt = (deg_eff == '0) ? polyev_pkg::ST_EMIT : polyev_pkg::ST_MUL;
        end
      end
      polyev_pkg::ST_MUL: begin
        state_nxt = polyev_pkg::ST_ADD;
      end
      polyev_pkg::ST_ADD: begin
        step_nxt  = step_r - 1'b1;
        state_nxt = (step_r == polyev_pkg::DEG_W'(1)) ? polyev_pkg::ST_EMIT
                                                      : polyev_pkg::ST_MUL;
      end
      polyev_pkg::ST_EMIT: begin
        if (status.out_free) begin
          state_nxt = polyev_pkg::ST_IDLE;
        end
      end
      default: state_nxt = polyev_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      polyev_pkg::ST_IDLE: begin
        in_stall     = 1'b0;
        cmd.load     = in_valid;
        cmd.coef_sel = deg_eff;
      end
      polyev_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
      end
      polyev_pkg::ST_ADD: begin
        cmd.add      = 1'b1;
        cmd.coef_sel = step_r - 1'b1;
      end
      polyev_pkg::ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= polyev_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// ===== sv/polynomial_evaluator_core.sv =====
// Horner polynomial evaluator, signed Q16.16. Each input transaction carries x;
// one output transaction returns p(x) = coef_0 + coef_1*x + ... + coef_d*x^d
// with d = degree (clamped to MAX_DEGREE), plus a sticky overflow bit set when
// any Horner step saturated to the signed 32-bit range. Config registers on the
// write port: index 0 = degree, 1..7 = coef_0..coef_6; write them only while
// idle. One item is processed at a time: after accept the sequencer runs a
// multiply state and an add state per degree step, then an emit state, and
// takes no new item until it is back in idle. The single shared 32x32
// multiplier is registered before the shift/add/saturate of each step. The
// next item is accepted while a finished result still waits under out_stall.
module polynomial_evaluator_core #(
  parameter int MAX_DEGREE = polyev_pkg::MAX_DEGREE_DEF,  // 1..6
  parameter int FRAC_BITS  = polyev_pkg::FRAC_BITS_DEF    // 0..30
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input transaction
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [polyev_pkg::DATA_W-1:0] in_x_value,
  // result transaction
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [polyev_pkg::DATA_W-1:0] out_poly_value,
  output logic                                 out_overflow,
  // configuration writes
  input  logic                                 cfg_wr_en,
  input  logic [polyev_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [polyev_pkg::DATA_W-1:0]        cfg_data
);

  logic [polyev_pkg::DEG_W-1:0] degree;
  polyev_pkg::coef_bank_t       coefs;
  polyev_pkg::dp_cmd_t          cmd;
  polyev_pkg::dp_status_t       status;

  // register file: degree and coefficients
  polyev_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .degree    (degree),
    .coefs     (coefs)
  );

  // sequencer: IDLE -> (MUL -> ADD) x d -> EMIT
  polyev_ctrl #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .degree   (degree),
    .status   (status),
    .cmd      (cmd)
  );

  // multiply, shift, add, saturate; owns the output register
  polyev_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .coefs          (coefs),
    .in_x_value     (in_x_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_poly_value (out_poly_value),
    .out_overflow   (out_overflow)
  );

endmodule

// ===== bench/polynomial_evaluator_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the config port, keeps a shadow of the register
// file, and predicts every result when its x transaction is accepted.
module polynomial_evaluator_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic signed [polyev_pkg::DATA_W-1:0] in_x_value,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [polyev_pkg::DATA_W-1:0] out_poly_value,
  input  logic                                 out_overflow,
  input  logic                                 cfg_wr_en,
  input  logic [polyev_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [polyev_pkg::DATA_W-1:0]        cfg_data,
  output int unsigned                          pending_results,
  output int unsigned                          fail_count
);
  import polyev_pkg::*;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam int unsigned MAX_REPORTS = 40;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              overflow;
  } poly_result_t;

  poly_result_t              expected_q[$];
  poly_result_t              want;
  logic [DEG_W-1:0]          degree_q;
  logic signed [DATA_W-1:0]  coef_q [NUM_COEFS];

  // Horner in Q16.16: 64-bit product, floor shift, add, saturate per step
  function automatic poly_result_t horner_eval(input logic signed [DATA_W-1:0] x);
    poly_result_t res;
    longint       acc;
    longint       sum;
    int           d;
    int           i;
    d = (degree_q > MAX_DEGREE_DEF) ? MAX_DEGREE_DEF : int'(degree_q);
    acc = longint'(coef_q[d]);
    res.overflow = 1'b0;
    for (i = d - 1; i >= 0; i--) begin
      sum = ((acc * longint'(x)) >>> FRAC_BITS_DEF) + longint'(coef_q[i]);
      if (sum > SAT_HI) begin
        sum = SAT_HI;
        res.overflow = 1'b1;
      end else if (sum < SAT_LO) begin
        sum = SAT_LO;
        res.overflow = 1'b1;
      end
      acc = sum;
    end
    res.value = acc[DATA_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want_bits);
    if (fail_count < MAX_REPORTS)
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want_bits);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_q.delete();
      degree_q = '0;
      foreach (coef_q[k]) coef_q[k] = '0;
    end else begin
      // result side first; an x accepted this edge cannot already be out
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result transaction", out_poly_value, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_poly_value !== want.value)
            report_mismatch("poly_value", out_poly_value, want.value);
          if (out_overflow !== want.overflow)
            report_mismatch("overflow", {31'd0, out_overflow}, {31'd0, want.overflow});
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(horner_eval(in_x_value));
      if (cfg_wr_en) begin
        if (cfg_index == REG_DEGREE)
          degree_q = cfg_data[DEG_W-1:0];
        else
          coef_q[cfg_index - REG_COEF0] = cfg_data;
      end
    end
    pending_results = expected_q.size();
  end

endmodule

// ===== bench/tb_polynomial_evaluator_core.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the Horner evaluator. The checker beside the DUT
// does all prediction and comparison; this module only drives the ports.
module tb_polynomial_evaluator_core;
  import polyev_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 12;
  // leave room past a full degree-6 evaluation from accept to result
  localparam int SETTLE_CYCLES  = 24;
  localparam int HOLD_CYCLES    = 400;
  localparam int SEGMENT_ITEMS  = 100;
  localparam int SEGMENTS       = 4;
  localparam longint TIMEOUT_CYCLES = 500_000;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_x_value;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_poly_value;
  logic                     out_overflow;
  logic                     cfg_wr_en;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [DATA_W-1:0]        cfg_data;

  int unsigned pending_results;
  int unsigned fail_count;

  // idle/stall odds in percent; src side read only by the stimulus process
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  logic        long_hold = 1'b0;
  bit          hold_go = 1'b0;

  // register image that load_config writes to the core
  logic [DEG_W-1:0]  deg_set;
  logic [DATA_W-1:0] coef_set [NUM_COEFS];

  always #(CLK_PERIOD / 2) clk = ~clk;

  polynomial_evaluator_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_x_value     (in_x_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_poly_value (out_poly_value),
    .out_overflow   (out_overflow),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  polynomial_evaluator_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_x_value      (in_x_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_poly_value  (out_poly_value),
    .out_overflow    (out_overflow),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pending_results (pending_results),
    .fail_count      (fail_count)
  );

  // Result side: random stall, overridden by the long hold-off window.
  always @(posedge clk)
    out_stall <= long_hold || ($urandom_range(99) < sink_stall_pct);

  // Long hold-off, counted here: the sender keeps offering meanwhile, so the
  // core finishes one item, takes the next, and then has to stall its input.
  initial begin
    wait (hold_go);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Hard stop in case a transaction never completes.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Mostly small magnitudes so plenty of results stay in range; the rest are
  // the two extremes and full 32-bit random patterns.
  function automatic logic [DATA_W-1:0] pick_q16(input int unsigned mag_bits);
    logic [DATA_W-1:0] v;
    case ($urandom_range(9))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2, 3: v = $urandom;
      default: begin
        v = $urandom_range((32'd1 << mag_bits) - 1);
        if ($urandom_range(1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  // One x transaction. valid stays high into the next call unless an idle
  // cycle is drawn, so back-to-back offers never toggle valid within a step.
  task automatic send_x(input logic [DATA_W-1:0] x);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_x_value <= x;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait until every predicted result has come back, then
  // let the settle period pass before anything else is touched.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes degree and all seven coefficients from the register image.
  task automatic load_config();
    int k;
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_DEGREE;
    cfg_data  <= {{(DATA_W-DEG_W){1'b0}}, deg_set};
    @(posedge clk);
    for (k = 0; k < NUM_COEFS; k++) begin
      cfg_index <= REG_COEF0 + CFG_IDX_W'(k);
      cfg_data  <= coef_set[k];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic reconfigure();
    drain();
    load_config();
  endtask

  task automatic fill_coefs(input logic [DATA_W-1:0] v);
    int k;
    for (k = 0; k < NUM_COEFS; k++) coef_set[k] = v;
  endtask

  initial begin
    int phase;
    int seg;
    int n;
    int k;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_x_value = '0;
    cfg_wr_en  = 1'b0;
    cfg_index  = REG_DEGREE;
    cfg_data   = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers at reset value: degree 0, zero constant term
    send_x(32'h1234_5678);

    // degree 0 returns coef_0 untouched, never overflows
    deg_set = 3'd0;
    fill_coefs(32'h0000_0000);
    coef_set[0] = 32'h8000_0000;
    reconfigure();
    send_x(32'h7FFF_FFFF);

    // degree 7 clamps to 6; all-max coefficients drive saturation both ways
    deg_set = 3'd7;
    fill_coefs(32'h7FFF_FFFF);
    reconfigure();
    send_x(32'h7FFF_FFFF);
    send_x(32'h8000_0000);
    send_x(32'h0000_0000);
    send_x(32'hFFFF_FFFF);
    send_x(32'h0001_0000);

    // degree 6, all-min coefficients
    deg_set = 3'd6;
    fill_coefs(32'h8000_0000);
    reconfigure();
    send_x(32'h7FFF_FFFF);
    send_x(32'h8000_0000);
    send_x(32'hFFFF_FFFF);
    send_x(32'h0000_0001);

    // 0.5x^2 - 2x + 1 at a few exact points and one huge x
    deg_set = 3'd2;
    fill_coefs(32'h0000_0000);
    coef_set[0] = 32'h0001_0000;
    coef_set[1] = 32'hFFFE_0000;
    coef_set[2] = 32'h0000_8000;
    reconfigure();
    send_x(32'h0000_0000);
    send_x(32'h0001_0000);
    send_x(32'hFFFD_0000);
    send_x(32'h0002_8000);
    send_x(32'h7FFF_FFFF);

    // x + max: overflow on the single step, and the negative side in range
    deg_set = 3'd1;
    fill_coefs(32'h0000_0000);
    coef_set[0] = 32'h7FFF_FFFF;
    coef_set[1] = 32'h0001_0000;
    reconfigure();
    send_x(32'h0001_0000);
    send_x(32'hFFFF_0000);

    // Random part: three idle profiles, each split into segments that run
    // under a fresh random register set.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 14;
          sink_stall_pct <= 50;
        end
        1: begin
          src_idle_pct = 50;
          sink_stall_pct <= 14;
        end
        default: begin
          src_idle_pct = 0;
          sink_stall_pct <= 0;
        end
      endcase
      for (seg = 0; seg < SEGMENTS; seg++) begin
        deg_set = DEG_W'($urandom_range(7));
        for (k = 0; k < NUM_COEFS; k++) coef_set[k] = pick_q16(20);
        reconfigure();
        // back-pressure burst while the sender streams at full rate
        if (phase == 2 && seg == 1) hold_go = 1'b1;
        for (n = 0; n < SEGMENT_ITEMS; n++) send_x(pick_q16(18));
      end
    end

    drain();
    @(negedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== polynomial_evaluator_core.f =====
sv/polyev_pkg.sv
sv/polyev_regs.sv
sv/polyev_dp.sv
sv/polyev_ctrl.sv
sv/polynomial_evaluator_core.sv
bench/polynomial_evaluator_checker.sv
bench/tb_polynomial_evaluator_core.sv
